[hdl/utd_pkg.sv]
// Shared types and constants for the UTF-8 to UCS-2 decoder.
// No dependencies; every other file of the decoder imports it.
`default_nettype none

package utd_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [31:0] LINE_RESET = 32'd1;
   localparam logic [7:0]  NEWLINE    = 8'h0A;

   localparam logic [20:0] MIN_TWO   = 21'h00080;
   localparam logic [20:0] MIN_THREE = 21'h00800;
   localparam logic [20:0] MIN_FOUR  = 21'h10000;
   localparam logic [20:0] MAX_CODE  = 21'h10FFFF;
   localparam logic [20:0] SURR_LOW  = 21'h0D800;
   localparam logic [20:0] SURR_HIGH = 21'h0DFFF;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_BAD_LEAD = 3'd1,
      STATUS_BROKEN   = 3'd2,
      STATUS_RANGE    = 3'd3,
      STATUS_SUPP     = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_word_type;

   typedef struct packed {
      logic [15:0] code_unit;
      status_type  status;
      logic [31:0] line_count;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]  bytes_left;
      logic [2:0]  seq_length;
      logic [20:0] accumulator;
   } dec_state_type;

   typedef struct packed {
      logic [1:0]    count;
      rsp_word_type  word0;
      rsp_word_type  word1;
      dec_state_type state;
      logic [31:0]   line_count;
   } dec_out_type;

endpackage

`default_nettype wire

[hdl/utd_decode.sv]
// Byte decode step: next sequence state, line counter and up to two result words.
// Depends on utd_pkg.
`default_nettype none

module utd_decode (
   input  utd_pkg::req_word_type  req_word,
   input  utd_pkg::dec_state_type state,
   input  logic [31:0]            line_count,
   output utd_pkg::dec_out_type   dec
);
   import utd_pkg::*;

   typedef struct packed {
      logic          emit;
      rsp_word_type  word;
      dec_state_type state;
   } lead_type;

   function automatic lead_type lead_decode(logic [7:0] b, logic [31:0] line);
      lead_type r;
      r = '0;
      r.word.line_count = line;
      r.word.status     = STATUS_OK;
      case (b) inside
         [8'h00:8'h7F]: begin
            r.emit           = 1'b1;
            r.word.code_unit = {8'h00, b};
         end
         [8'hC0:8'hDF]: begin
            r.state.accumulator = {16'h0000, b[4:0]};
            r.state.bytes_left  = 2'd1;
            r.state.seq_length  = 3'd2;
         end
         [8'hE0:8'hEF]: begin
            r.state.accumulator = {17'h00000, b[3:0]};
            r.state.bytes_left  = 2'd2;
            r.state.seq_length  = 3'd3;
         end
         [8'hF0:8'hF7]: begin
            r.state.accumulator = {18'h00000, b[2:0]};
            r.state.bytes_left  = 2'd3;
            r.state.seq_length  = 3'd4;
         end
         default: begin
            r.emit        = 1'b1;
            r.word.status = STATUS_BAD_LEAD;
         end
      endcase
      return r;
   endfunction

   logic [7:0]   b;
   logic [31:0]  line_next;
   logic [20:0]  value;
   status_type   fin_status;
   lead_type     lead;
   rsp_word_type broken;
   rsp_word_type finished;

   assign b = req_word.in_byte;

   always_comb begin
      line_next = line_count;
      if (!req_word.end_of_text && b == NEWLINE && line_count != '1) begin
         line_next = line_count + 32'd1;
      end
   end

   assign value = {state.accumulator[14:0], b[5:0]};

   always_comb begin
      case (state.seq_length)
         3'd2: fin_status = (value >= MIN_TWO) ? STATUS_OK : STATUS_RANGE;
         3'd3: begin
            if (value < MIN_THREE || (value >= SURR_LOW && value <= SURR_HIGH)) begin
               fin_status = STATUS_RANGE;
            end else begin
               fin_status = STATUS_OK;
            end
         end
         default: begin
            fin_status = (value >= MIN_FOUR && value <= MAX_CODE) ?
                         STATUS_SUPP : STATUS_RANGE;
         end
      endcase
   end

   assign lead = lead_decode(b, line_next);

   always_comb begin
      broken            = '0;
      broken.status     = STATUS_BROKEN;
      broken.line_count = line_next;
      finished            = '0;
      finished.status     = fin_status;
      finished.line_count = line_next;
      finished.code_unit  = (fin_status == STATUS_OK) ? value[15:0] : 16'h0000;
   end

   always_comb begin
      dec            = '0;
      dec.state      = state;
      dec.line_count = line_next;
      if (req_word.end_of_text) begin
         if (state.bytes_left != 2'd0) begin
            dec.count = 2'd1;
            dec.word0 = broken;
            dec.state = '0;
         end
      end else if (state.bytes_left == 2'd0) begin
         dec.state = lead.state;
         dec.word0 = lead.word;
         dec.count = {1'b0, lead.emit};
      end else if (b[7:6] == 2'b10) begin
         dec.state.accumulator = value;
         dec.state.bytes_left  = state.bytes_left - 2'd1;
         if (state.bytes_left == 2'd1) begin
            dec.count = 2'd1;
            dec.word0 = finished;
            dec.state = '0;
         end
      end else begin
         dec.state = lead.state;
         dec.word0 = broken;
         dec.word1 = lead.word;
         dec.count = lead.emit ? 2'd2 : 2'd1;
      end
      if (dec.count == 2'd1) begin
         dec.word0.last = 1'b1;
      end
      if (dec.count == 2'd2) begin
         dec.word1.last = 1'b1;
      end
   end

endmodule

`default_nettype wire

[hdl/utd_queue.sv]
// Result word queue: takes up to two words a cycle, hands out one.
// Depends on utd_pkg.
`default_nettype none

module utd_queue #(
   parameter int unsigned DEPTH = utd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_count,
   input  utd_pkg::rsp_word_type push_word0,
   input  utd_pkg::rsp_word_type push_word1,
   output logic                  space_two,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output utd_pkg::rsp_word_type pop_word
);
   import utd_pkg::*;

   localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

   function automatic logic [PTR_W-1:0] wrap_inc(logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   rsp_word_type         mem [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]     wr_ptr_one;
   logic                 pop;

   assign wr_ptr_one = wrap_inc(wr_ptr_ff);
   assign pop        = pop_valid & pop_ready;
   assign pop_valid  = count_ff != '0;
   assign pop_word   = mem[rd_ptr_ff];
   assign space_two  = count_ff <= COUNT_W'(DEPTH - 2);

   always_comb begin
      case (push_count)
         2'd1:    wr_ptr_in = wr_ptr_one;
         2'd2:    wr_ptr_in = wrap_inc(wr_ptr_one);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + COUNT_W'(push_count) - COUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem[wr_ptr_ff] <= push_word0;
      end
      if (push_count == 2'd2) begin
         mem[wr_ptr_one] <= push_word1;
      end
   end

endmodule

`default_nettype wire

[hdl/utf8_to_ucs2_decoder.sv]
// UTF-8 to UCS-2 decoder top level: decode step, sequence state, line counter, result queue.
// Result words are written into the result queue when their byte is accepted and are offered from it in order.
// Throughput: one byte per cycle; a byte that yields two words hands them out one after the other,
// and input stalls only while the queue holds fewer than two free entries.
// Reset: sequence state idle, line counter 1, result queue empty.
`default_nettype none

module utf8_to_ucs2_decoder #(
   parameter int unsigned QUEUE_DEPTH = utd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  utd_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output utd_pkg::rsp_word_type rsp_word
);
   import utd_pkg::*;

   dec_state_type state_ff, state_in;
   logic [31:0]   line_ff, line_in;
   dec_out_type   dec;
   logic          req_accept;
   logic [1:0]    push_count;

   assign req_accept = req_valid & req_ready;
   assign push_count = req_accept ? dec.count : 2'd0;

   utd_decode u_decode (
      .req_word   (req_word),
      .state      (state_ff),
      .line_count (line_ff),
      .dec        (dec)
   );

   always_comb begin
      state_in = state_ff;
      line_in  = line_ff;
      if (req_accept) begin
         state_in = dec.state;
         line_in  = dec.line_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         line_ff  <= LINE_RESET;
      end else begin
         state_ff <= state_in;
         line_ff  <= line_in;
      end
   end

   utd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_word0 (dec.word0),
      .push_word1 (dec.word1),
      .space_two  (req_ready),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_word   (rsp_word)
   );

endmodule

`default_nettype wire

[hdl/utd_checker.sv]
// Port-level checks for the UTF-8 to UCS-2 decoder, bound to the top level.
// Depends on utd_pkg and utf8_to_ucs2_decoder.
`default_nettype none

module utd_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire utd_pkg::req_word_type req_word,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire utd_pkg::rsp_word_type rsp_word
);
   import utd_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_word))
      else $error("input word dropped or changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != STATUS_OK |-> rsp_word.code_unit == 16'h0000)
      else $error("error word carries a code unit");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.line_count != 32'd0)
      else $error("line count wrapped to zero");

endmodule

bind utf8_to_ucs2_decoder utd_checker u_checker (.*);

`default_nettype wire
